// ===== src/pending_query_ring_with_dedup_defines.svh =====
// ----------------------------------------------------------------------------
// Pending query ring assertion macros
// Shared property forms for the checker of the pending query ring.
// ----------------------------------------------------------------------------
`ifndef PENDING_QUERY_RING_WITH_DEDUP_DEFINES_SVH
`define PENDING_QUERY_RING_WITH_DEDUP_DEFINES_SVH

// Antecedent in a cycle implies the consequent in the next cycle.
`define PQR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define PQR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define PQR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pqr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pending query ring package
// Types, sizes, action codes and ring helpers shared by the ring modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pqr_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam logic [31:0] TIMEOUT_RESET = 32'd4000;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_ANSWER = 2'd2;
  localparam logic [1:0] ACT_CHECK  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] query_id;
    logic [15:0] query_type;
    logic [7:0]  name_length;
    logic [63:0] name_key;
    logic [15:0] item_handle;
    logic [31:0] now_time;
    logic [31:0] prior_wait;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [15:0] handle_out;
    logic        timed_out;
    logic [31:0] wait_out;
    logic        overwrote_pending;
  } rsp_t;

  // One stored request record.
  typedef struct packed {
    logic [15:0] query_id;
    logic [15:0] query_type;
    logic [7:0]  name_length;
    logic [63:0] name_key;
    logic [15:0] item_handle;
    logic [31:0] recv_time;
  } rec_t;

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
    logic        zero;
    logic        match;
  } alu_res_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

// ===== src/pqr_mem.sv =====
// ----------------------------------------------------------------------------
// Pending query ring record memory
// One write port and one registered read port over the record ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqr_mem
  import pqr_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pqr_alu.sv =====
// ----------------------------------------------------------------------------
// Pending query ring shared compare unit
// A 32-bit subtractor with borrow and zero flags, and the record identity
// comparator used by the duplicate search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqr_alu
  import pqr_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  rec_t        rec,
  input  req_t        probe,
  output alu_res_t    res
);

  logic [32:0] sub;

  assign sub        = {1'b0, a} - {1'b0, b};
  assign res.diff   = sub[31:0];
  assign res.borrow = sub[32];
  assign res.zero   = (sub[31:0] == 32'd0);
  assign res.match  = (rec.query_id == probe.query_id) &&
                      (rec.query_type == probe.query_type) &&
                      (rec.name_length == probe.name_length) &&
                      (rec.name_key == probe.name_key);

endmodule

// ===== src/pending_query_ring_with_dedup.sv =====
// ----------------------------------------------------------------------------
// Pending query ring with duplicate lookup
// Ring of recent request records with append, duplicate search, answer and
// timeout check actions, run by a small sequencer around one shared unit.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is issued by raising start with the request on req; it is
// taken at a rising edge where start is high and busy is low. Every
// transaction yields exactly one response, shown on rsp for one cycle while
// done is high. The receiver cannot stall, so it must sample rsp whenever
// done is high.
// Append and answer complete at the accepting edge: the response appears in
// the next cycle and busy never rises, so they may be issued every cycle.
// A lookup walks the stored records oldest first, one record per cycle
// through the registered read port of the record memory, until all stored
// records (up to 64) are compared. A hit ends the walk early. An empty ring
// answers in the next cycle.
// A timeout check reads the oldest pending record and then uses the shared
// subtractor for the age, the time left and the minimum with the prior wait,
// in that order; a timed-out record ends it after the time-left step. With
// nothing pending it answers in the next cycle.
// Reset (rst, synchronous) empties the ring and sets the timeout to 4000.
// The timeout register is written through cfg_we and cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pending_query_ring_with_dedup
  import pqr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOK     = 3'd1;
  localparam logic [2:0] S_CHK_AGE  = 3'd2;
  localparam logic [2:0] S_CHK_TO   = 3'd3;
  localparam logic [2:0] S_CHK_WAIT = 3'd4;

  logic [2:0]       state, state_next;
  logic             done_next;
  logic             done_next_q;
  logic [31:0]      timeout_ticks;

  // Ring pointers and counts.
  logic [IDX_W-1:0] oldest_index, oldest_index_next;
  logic [IDX_W-1:0] tail_index, tail_index_next;
  logic [IDX_W-1:0] pending_index, pending_index_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [CNT_W-1:0] pending_count, pending_count_next;

  // Search walk: read pointer, reads still to issue, and flags that are
  // registered together with the read data from each read address.
  logic [IDX_W-1:0] scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0] scan_left, scan_left_next;
  logic             cmp_valid, cmp_valid_next;
  logic             cmp_last, cmp_last_next;

  // Datapath registers: the accepted request, a working value (age, then
  // time left) and the handle of the pending record under check.
  req_t             item;
  logic [31:0]      acc, acc_next;
  logic [15:0]      chk_handle, chk_handle_next;
  rsp_t             rsp_q, rsp_next;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_rec;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  rec_t             rd_rec;
  logic [31:0]      alu_a, alu_b;
  alu_res_t         alu;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign done   = done_next_q;
  assign rsp    = rsp_q;

  // Append and answer write their record at the accepting edge, straight
  // from the request.
  assign wr_rec.query_id    = req.query_id;
  assign wr_rec.query_type  = req.query_type;
  assign wr_rec.name_length = req.name_length;
  assign wr_rec.name_key    = req.name_key;
  assign wr_rec.item_handle = req.item_handle;
  assign wr_rec.recv_time   = req.now_time;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_index;
    if (accept) begin
      if (req.action == ACT_APPEND) begin
        wr_en = 1'b1;
      end else if (req.action == ACT_ANSWER && pending_count != '0) begin
        wr_en   = 1'b1;
        wr_addr = pending_index;
      end
    end
  end

  // The check reads the oldest pending record at its accepting edge; the
  // search issues one read per cycle while records remain.
  always_comb begin
    if (state == S_IDLE) begin
      rd_en   = accept && (req.action == ACT_CHECK);
      rd_addr = pending_index;
    end else begin
      rd_en   = (state == S_LOOK) && (scan_left != '0);
      rd_addr = scan_ptr;
    end
  end

  pqr_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  // Operand selection for the shared subtractor, one step of the check
  // per state.
  always_comb begin
    unique case (state)
      S_CHK_AGE: begin
        alu_a = item.now_time;
        alu_b = rd_rec.recv_time;
      end
      S_CHK_TO: begin
        alu_a = timeout_ticks;
        alu_b = acc;
      end
      S_CHK_WAIT: begin
        alu_a = item.prior_wait;
        alu_b = acc;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  pqr_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .rec   (rd_rec),
    .probe (item),
    .res   (alu)
  );

  always_comb begin
    state_next         = state;
    done_next          = 1'b0;
    rsp_next           = rsp_q;
    acc_next           = acc;
    chk_handle_next    = chk_handle;
    oldest_index_next  = oldest_index;
    tail_index_next    = tail_index;
    pending_index_next = pending_index;
    stored_count_next  = stored_count;
    pending_count_next = pending_count;
    scan_ptr_next      = scan_ptr;
    scan_left_next     = scan_left;
    cmp_valid_next     = 1'b0;
    cmp_last_next      = cmp_last;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_next          = '0;
          rsp_next.wait_out = req.prior_wait;
          unique case (req.action)
            ACT_APPEND: begin
              // A ring full of pending records loses its oldest pending one.
              if (pending_count == CNT_W'(RING_DEPTH)) begin
                rsp_next.overwrote_pending = 1'b1;
                pending_index_next         = ring_next(pending_index);
              end else begin
                pending_count_next = pending_count + 1'b1;
              end
              if (stored_count == CNT_W'(RING_DEPTH)) begin
                oldest_index_next = ring_next(oldest_index);
              end else begin
                stored_count_next = stored_count + 1'b1;
              end
              tail_index_next = ring_next(tail_index);
              done_next       = 1'b1;
            end
            ACT_LOOKUP: begin
              if (stored_count == '0) begin
                done_next = 1'b1;
              end else begin
                scan_ptr_next  = oldest_index;
                scan_left_next = stored_count;
                state_next     = S_LOOK;
              end
            end
            ACT_ANSWER: begin
              if (pending_count == '0) begin
                rsp_next.status = 1'b1;
              end else begin
                pending_index_next = ring_next(pending_index);
                pending_count_next = pending_count - 1'b1;
              end
              done_next = 1'b1;
            end
            ACT_CHECK: begin
              if (pending_count == '0) begin
                rsp_next.status = 1'b1;
                done_next       = 1'b1;
              end else begin
                state_next = S_CHK_AGE;
              end
            end
          endcase
        end
      end
      S_LOOK: begin
        if (scan_left != '0) begin
          scan_ptr_next  = ring_next(scan_ptr);
          scan_left_next = scan_left - 1'b1;
        end
        cmp_valid_next = (scan_left != '0);
        cmp_last_next  = (scan_left == CNT_W'(1));
        // The oldest match wins, since records are compared in ring order.
        if (cmp_valid && alu.match) begin
          rsp_next            = '0;
          rsp_next.wait_out   = item.prior_wait;
          rsp_next.hit        = 1'b1;
          rsp_next.handle_out = rd_rec.item_handle;
          done_next           = 1'b1;
          state_next          = S_IDLE;
        end else if (cmp_valid && cmp_last) begin
          rsp_next          = '0;
          rsp_next.wait_out = item.prior_wait;
          done_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_CHK_AGE: begin
        // Age wraps modulo 2^32, so a receive time ahead of now is old.
        acc_next        = alu.diff;
        chk_handle_next = rd_rec.item_handle;
        state_next      = S_CHK_TO;
      end
      S_CHK_TO: begin
        if (alu.borrow || alu.zero) begin
          rsp_next            = '0;
          rsp_next.wait_out   = item.prior_wait;
          rsp_next.handle_out = chk_handle;
          rsp_next.timed_out  = 1'b1;
          done_next           = 1'b1;
          state_next          = S_IDLE;
        end else begin
          acc_next   = alu.diff;
          state_next = S_CHK_WAIT;
        end
      end
      S_CHK_WAIT: begin
        // Keep the smaller of the time left and the prior wait.
        rsp_next            = '0;
        rsp_next.handle_out = chk_handle;
        rsp_next.wait_out   = (!alu.borrow && !alu.zero) ? acc : item.prior_wait;
        done_next           = 1'b1;
        state_next          = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done_next_q   <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
      oldest_index  <= '0;
      tail_index    <= '0;
      pending_index <= '0;
      stored_count  <= '0;
      pending_count <= '0;
      scan_ptr      <= '0;
      scan_left     <= '0;
      cmp_valid     <= 1'b0;
      cmp_last      <= 1'b0;
    end else begin
      state         <= state_next;
      done_next_q   <= done_next;
      oldest_index  <= oldest_index_next;
      tail_index    <= tail_index_next;
      pending_index <= pending_index_next;
      stored_count  <= stored_count_next;
      pending_count <= pending_count_next;
      scan_ptr      <= scan_ptr_next;
      scan_left     <= scan_left_next;
      cmp_valid     <= cmp_valid_next;
      cmp_last      <= cmp_last_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    acc        <= acc_next;
    chk_handle <= chk_handle_next;
    rsp_q      <= rsp_next;
  end

endmodule

// ===== src/pqr_chk.sv =====
// ----------------------------------------------------------------------------
// Pending query ring port checker
// Watches the top-level ports of the pending query ring over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pending_query_ring_with_dedup_defines.svh"

module pqr_chk
  import pqr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input req_t        req,
  input logic        done,
  input rsp_t        rsp
);

  logic accept;
  logic quick;

  assign accept = start && !busy;
  assign quick  = accept && (req.action == ACT_APPEND || req.action == ACT_ANSWER);

  // Leaving reset, the block is idle and shows no response.
  `PQR_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !busy && !done, "not idle after reset")

  // Append and answer transactions respond in the very next cycle.
  `PQR_ASSERT_NEXT(a_quick_resp, clk, rst, quick, done && !busy, "append or answer late")

  // A response is only shown while the block is not busy.
  `PQR_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "response while still busy")

  // Busy only rises after an accepted transaction.
  `PQR_ASSERT_SAME(a_busy_cause, clk, rst, $rose(busy), $past(accept), "busy without request")

  // A hit never comes with an error status or a timeout flag.
  `PQR_ASSERT_SAME(a_hit_clean, clk, rst, done && rsp.hit, !rsp.status && !rsp.timed_out,
                   "inconsistent hit response")

endmodule

bind pending_query_ring_with_dedup pqr_chk u_pqr_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req       (req),
  .done      (done),
  .rsp       (rsp)
);
